[hw/rtl/gwm_pkg.sv]
// Shared types, codes and helpers for the glob wildcard matcher.
package gwm_pkg;

  localparam logic [1:0] OP_PAT_WR = 2'd0;
  localparam logic [1:0] OP_ENTRY  = 2'd1;
  localparam logic [1:0] OP_EMPTY  = 2'd2;

  localparam logic REG_CASE_SENSITIVE = 1'b0;
  localparam logic REG_PATTERN_LENGTH = 1'b1;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;

  // Per-transfer control broadcast to every cell.
  typedef struct packed {
    logic use_init;  // evaluate from the start set (empty entry)
    logic load;      // capture the advanced set
    logic restart;   // entry finished, back to the start set
  } gwm_ctl_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic case_sens);
    logic [7:0] r;
    r = c;
    if (!case_sens && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[hw/rtl/gwm_cell.sv]
// One pattern position: stored pattern byte, active bit and its links to the neighbors.
module gwm_cell
  import gwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       init_bit,
  input  gwm_ctl_t   ctl,
  input  logic       pos_en,
  input  logic       case_sens,
  input  logic [7:0] ch_f,
  input  logic       pat_we,
  input  logic [7:0] pat_data,
  input  logic       c_in,
  input  logic       adv_in,
  input  logic       n_in,
  output logic       c_out,
  output logic       adv_out,
  output logic       n_out,
  output logic       c_here,
  output logic       n_here,
  output logic       act_q
);

  logic [7:0] pat_r;
  logic       act_r;
  logic       act_nxt;
  logic       is_star;
  logic       hit;

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_r <= pat_data;
    end
  end

  assign is_star = (pat_r == CH_STAR);
  assign hit     = (pat_r == CH_QUEST) || (fold_char(pat_r, case_sens) == ch_f);

  // closure of the held set, then one step on the entry byte, then closure again
  assign c_here  = (ctl.use_init ? init_bit : act_r) | c_in;
  assign c_out   = c_here & pos_en & is_star;
  assign adv_out = c_here & pos_en & ~is_star & hit;
  assign n_here  = c_out | adv_in | n_in;
  assign n_out   = n_here & pos_en & is_star;

  always_comb begin
    act_nxt = act_r;
    if (ctl.restart) begin
      act_nxt = init_bit;
    end else if (ctl.load) begin
      act_nxt = n_here;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= init_bit;
    end else begin
      act_r <= act_nxt;
    end
  end

  assign act_q = act_r;

endmodule

[hw/rtl/glob_wildcard_matcher.sv]
// Top level of the glob wildcard matcher: cell row, configuration and result register.
//
// Input channel (in_*): opcode 0 writes pattern byte in_char_value at in_pattern_index,
// opcode 1 feeds one entry byte (in_last marks the final one), opcode 2 judges an
// empty entry; opcode 3 is dropped. Each cell of the row holds one pattern byte and
// one active-position bit; a star propagates activity to the right like a carry chain,
// so the whole active set advances by one entry byte per cycle.
// Result channel (out_*): one transfer per finished entry (opcode 1 with last, or
// opcode 2), out_matched high when the entry matches. out_valid rises in the cycle
// after the input transfer. Throughput is one item per cycle; the output register
// lets a new item in whenever it is empty or being drained in the same cycle, so a
// stalled receiver holds back the input only while a result is waiting.
// Configuration (cfg_*): index 0 case_sensitive, index 1 pattern_length; always ready.
// The user writes it only while the block is idle (unenforced). Length 0 matches every entry.
// Reset (synchronous, rst_n low): case sensitive, length 0, only position zero active,
// output empty. Pattern bytes are undefined until written.
module glob_wildcard_matcher
  import gwm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [4:0] in_pattern_index,
  input  logic [7:0] in_char_value,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_matched,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data
);

  localparam int         LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [5:0] MAX6  = 6'(PATTERN_MAX);

  // configuration registers
  logic       case_sens_r;
  logic [5:0] len_r;
  logic       cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_sens_r <= 1'b1;
      len_r       <= 6'd0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_CASE_SENSITIVE: case_sens_r <= cfg_data[0];
        REG_PATTERN_LENGTH: len_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // lengths above the row size clamp to the row size
  logic [LEN_W-1:0] eff_len;
  assign eff_len = (len_r > MAX6) ? LEN_W'(PATTERN_MAX) : LEN_W'(len_r);

  // input handshake and decode
  logic     in_fire;
  logic     is_entry;
  logic     is_empty;
  logic     is_result;
  gwm_ctl_t ctl;
  logic [7:0] ch_f;

  logic out_valid_r, out_valid_nxt;
  logic out_matched_r, out_matched_nxt;

  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;
  assign is_entry  = in_fire & (in_opcode == OP_ENTRY);
  assign is_empty  = in_fire & (in_opcode == OP_EMPTY);
  assign is_result = is_empty | (is_entry & in_last);

  assign ctl.use_init = (in_opcode == OP_EMPTY);
  assign ctl.load     = is_entry;
  assign ctl.restart  = is_result;

  assign ch_f = fold_char(in_char_value, case_sens_r);

  // cell row; links carry closure, advance and post-advance closure rightward
  logic [PATTERN_MAX:0]   c_link, adv_link, n_link;
  logic [PATTERN_MAX:0]   c_vec, n_vec;
  logic [PATTERN_MAX-1:0] act_vec;

  assign c_link[0]   = 1'b0;
  assign adv_link[0] = 1'b0;
  assign n_link[0]   = 1'b0;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic pat_we;
    logic pos_en;
    assign pat_we = in_fire && (in_opcode == OP_PAT_WR) &&
                    ({1'b0, in_pattern_index} == 6'(i));
    assign pos_en = (LEN_W'(i) < eff_len);

    gwm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .init_bit ((i == 0) ? 1'b1 : 1'b0),
      .ctl      (ctl),
      .pos_en   (pos_en),
      .case_sens(case_sens_r),
      .ch_f     (ch_f),
      .pat_we   (pat_we),
      .pat_data (in_char_value),
      .c_in     (c_link[i]),
      .adv_in   (adv_link[i]),
      .n_in     (n_link[i]),
      .c_out    (c_link[i+1]),
      .adv_out  (adv_link[i+1]),
      .n_out    (n_link[i+1]),
      .c_here   (c_vec[i]),
      .n_here   (n_vec[i]),
      .act_q    (act_vec[i])
    );
  end

  // the end position has no cell; only its left neighbor can reach it
  assign c_vec[PATTERN_MAX] = c_link[PATTERN_MAX];
  assign n_vec[PATTERN_MAX] = adv_link[PATTERN_MAX] | n_link[PATTERN_MAX];

  // result register: match means the end position is active
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    if (is_result) begin
      out_valid_nxt = 1'b1;
      if (eff_len == '0) begin
        out_matched_nxt = 1'b1;
      end else if (is_empty) begin
        out_matched_nxt = c_vec[eff_len];
      end else begin
        out_matched_nxt = n_vec[eff_len];
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  // a waiting result blocks new transfers
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  // every finished entry leaves only position zero active
  assert property (@(posedge clk) disable iff (!rst_n)
    is_result |=> (act_vec == PATTERN_MAX'(1)))
    else $error("active set not restarted after result");

  // empty pattern matches the empty entry
  assert property (@(posedge clk) disable iff (!rst_n)
    (is_empty && (len_r == 6'd0)) |=> (out_valid && out_matched))
    else $error("zero-length pattern did not match");

  // length write lands in the register
  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_fire && (cfg_index == REG_PATTERN_LENGTH)) |=> (len_r == $past(cfg_data)))
    else $error("pattern length write lost");

endmodule
